FILE: hw/rtl/euler_rpy_to_quaternion_defines.svh
// Assertion helpers shared by the modules of the Euler-to-quaternion block.
// They expect signals named clock and reset in the scope of use.
`ifndef EULER_RPY_TO_QUATERNION_DEFINES_SVH
`define EULER_RPY_TO_QUATERNION_DEFINES_SVH

// Same-cycle implication.
`define ERQ_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ERQ_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/erq_pkg.sv
package erq_pkg;

   localparam int ANGLE_BITS_DEF   = 16;
   localparam int QUAT_BITS_DEF    = 16;
   localparam int CORDIC_STEPS_DEF = 16;

   // CORDIC x/y are Q2.30; z is the half angle at 2^33 units per turn.
   localparam int XY_W   = 32;
   localparam int Z_W    = 34;
   localparam int PAIR_W = 33;
   localparam int TERM_W = XY_W + PAIR_W;
   localparam int SUM_W  = TERM_W + 1;

   // Stages after the CORDIC: pair products, term products, sums, saturation.
   localparam int POST_STAGES = 4;

   typedef logic signed [XY_W-1:0]   xy_type;
   typedef logic signed [Z_W-1:0]    z_type;
   typedef logic signed [PAIR_W-1:0] pair_type;
   typedef logic signed [TERM_W-1:0] term_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   localparam xy_type GAIN_Q30 = 32'sh26DD3B6A;

   // atan(2^-i) in units of 2^32 per turn.
   localparam logic signed [31:0] ATAN_TAB [32] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
      32'sd42667331,  32'sd21354465,  32'sd10680862,  32'sd5340245,
      32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
      32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
      32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
      32'sd652,       32'sd326,       32'sd163,       32'sd81,
      32'sd41,        32'sd20,        32'sd10,        32'sd5,
      32'sd3,         32'sd1,         32'sd1,         32'sd0
   };

endpackage

FILE: hw/rtl/euler_rpy_to_quaternion.sv
// Channel    Direction  Handshake             Payload
// req        in         req_valid/req_stall   roll, pitch, yaw binary angles
// rsp        out        rsp_valid/rsp_stall   quaternion x, y, z, w (Q1.15 at default)
//
// The pipeline has one register per CORDIC iteration in three parallel angle
// lanes, then pair products, term products, sums and saturation. One beat is
// accepted per cycle when the output flows.
// A held output stalls only the stages behind it that are full; bubbles close up.
// Reset is synchronous and clears the valid bits only.
`include "euler_rpy_to_quaternion_defines.svh"

module euler_rpy_to_quaternion #(
   parameter int ANGLE_BITS   = erq_pkg::ANGLE_BITS_DEF,
   parameter int QUAT_BITS    = erq_pkg::QUAT_BITS_DEF,
   parameter int CORDIC_STEPS = erq_pkg::CORDIC_STEPS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [ANGLE_BITS-1:0] req_roll_angle,
   input  logic signed [ANGLE_BITS-1:0] req_pitch_angle,
   input  logic signed [ANGLE_BITS-1:0] req_yaw_angle,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [QUAT_BITS-1:0]  rsp_quat_x,
   output logic signed [QUAT_BITS-1:0]  rsp_quat_y,
   output logic signed [QUAT_BITS-1:0]  rsp_quat_z,
   output logic signed [QUAT_BITS-1:0]  rsp_quat_w
);

   import erq_pkg::*;

   localparam int DEPTH = CORDIC_STEPS + POST_STAGES;
   localparam logic [QUAT_BITS-1:0] MOST_NEG = {1'b1, {(QUAT_BITS-1){1'b0}}};

   logic [DEPTH-1:0] load;
   xy_type sr, cr, sp, cp, sy, cy;
   logic no_most_neg;

   erq_pipe_ctl #(
      .DEPTH (DEPTH)
   ) u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .load      (load)
   );

   erq_cordic #(
      .ANGLE_BITS   (ANGLE_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_roll (
      .clock   (clock),
      .angle   (req_roll_angle),
      .load    (load[CORDIC_STEPS-1:0]),
      .sin_val (sr),
      .cos_val (cr)
   );

   erq_cordic #(
      .ANGLE_BITS   (ANGLE_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_pitch (
      .clock   (clock),
      .angle   (req_pitch_angle),
      .load    (load[CORDIC_STEPS-1:0]),
      .sin_val (sp),
      .cos_val (cp)
   );

   erq_cordic #(
      .ANGLE_BITS   (ANGLE_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_yaw (
      .clock   (clock),
      .angle   (req_yaw_angle),
      .load    (load[CORDIC_STEPS-1:0]),
      .sin_val (sy),
      .cos_val (cy)
   );

   erq_combine #(
      .QUAT_BITS (QUAT_BITS)
   ) u_combine (
      .clock  (clock),
      .load   (load[DEPTH-1:CORDIC_STEPS]),
      .sr     (sr),
      .cr     (cr),
      .sp     (sp),
      .cp     (cp),
      .sy     (sy),
      .cy     (cy),
      .quat_x (rsp_quat_x),
      .quat_y (rsp_quat_y),
      .quat_z (rsp_quat_z),
      .quat_w (rsp_quat_w)
   );

   assign no_most_neg = (rsp_quat_x != MOST_NEG) && (rsp_quat_y != MOST_NEG) &&
                        (rsp_quat_z != MOST_NEG) && (rsp_quat_w != MOST_NEG);

   `ERQ_ASSERT_IMP(a_symmetric_sat, rsp_valid, no_most_neg, "component below the negative limit")

endmodule

FILE: hw/rtl/erq_pipe_ctl.sv
`include "euler_rpy_to_quaternion_defines.svh"

module erq_pipe_ctl #(
   parameter int DEPTH = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [DEPTH-1:0] load
);

   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic [DEPTH-1:0] ready;

   // A stage may take a new beat unless it and every stage after it are full
   // and the output is held.
   for (genvar k = 0; k < DEPTH; k++) begin : g_ready
      assign ready[k] = !rsp_stall || !(&valid_ff[DEPTH-1:k]);
   end

   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         if (ready[k]) begin
            valid_in[k] = (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k-1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign load      = ready;
   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[DEPTH-1];

   `ERQ_ASSERT_IMP(a_flow_no_stall, !rsp_stall, !req_stall, "input stalled while output flows")
   `ERQ_ASSERT_NXT(a_full_holds, rsp_stall && (&valid_ff), $stable(valid_ff), "held pipe moved")
   `ERQ_ASSERT_NXT(a_accept_enters, req_valid && !req_stall, valid_ff[0], "beat lost at entry")

endmodule

FILE: hw/rtl/erq_cordic.sv
module erq_cordic #(
   parameter int ANGLE_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                           clock,
   input  logic signed [ANGLE_BITS-1:0]   angle,
   input  logic        [CORDIC_STEPS-1:0] load,
   output erq_pkg::xy_type                sin_val,
   output erq_pkg::xy_type                cos_val
);

   import erq_pkg::*;

   localparam int ZSHIFT = 32 - ANGLE_BITS;

   xy_type x_ff [CORDIC_STEPS];
   xy_type y_ff [CORDIC_STEPS];
   z_type  z_ff [CORDIC_STEPS-1];
   xy_type x_in [CORDIC_STEPS];
   xy_type y_in [CORDIC_STEPS];
   z_type  z_in [CORDIC_STEPS-1];
   z_type  z_init;

   // Scaling to 2^32 units per turn halves the angle, since z counts 2^33 per turn.
   assign z_init = z_type'({{(Z_W-ANGLE_BITS){angle[ANGLE_BITS-1]}}, angle}) <<< ZSHIFT;

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      localparam z_type STEP = z_type'(ATAN_TAB[k]) <<< 1;
      xy_type x_cur;
      xy_type y_cur;
      z_type  z_cur;

      if (k == 0) begin : g_first
         assign x_cur = GAIN_Q30;
         assign y_cur = '0;
         assign z_cur = z_init;
      end else begin : g_next
         assign x_cur = x_ff[k-1];
         assign y_cur = y_ff[k-1];
         assign z_cur = z_ff[k-1];
      end

      always_comb begin
         if (!z_cur[Z_W-1]) begin
            x_in[k] = x_cur - (y_cur >>> k);
            y_in[k] = y_cur + (x_cur >>> k);
         end else begin
            x_in[k] = x_cur + (y_cur >>> k);
            y_in[k] = y_cur - (x_cur >>> k);
         end
      end

      if (k < CORDIC_STEPS-1) begin : g_z
         assign z_in[k] = z_cur[Z_W-1] ? z_cur + STEP : z_cur - STEP;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < CORDIC_STEPS; k++) begin
         if (load[k]) begin
            x_ff[k] <= x_in[k];
            y_ff[k] <= y_in[k];
         end
      end
      for (int k = 0; k < CORDIC_STEPS-1; k++) begin
         if (load[k]) begin
            z_ff[k] <= z_in[k];
         end
      end
   end

   assign sin_val = y_ff[CORDIC_STEPS-1];
   assign cos_val = x_ff[CORDIC_STEPS-1];

endmodule

FILE: hw/rtl/erq_combine.sv
module erq_combine #(
   parameter int QUAT_BITS = 16
) (
   input  logic                                   clock,
   input  logic [erq_pkg::POST_STAGES-1:0]        load,
   input  erq_pkg::xy_type                        sr,
   input  erq_pkg::xy_type                        cr,
   input  erq_pkg::xy_type                        sp,
   input  erq_pkg::xy_type                        cp,
   input  erq_pkg::xy_type                        sy,
   input  erq_pkg::xy_type                        cy,
   output logic signed [QUAT_BITS-1:0]            quat_x,
   output logic signed [QUAT_BITS-1:0]            quat_y,
   output logic signed [QUAT_BITS-1:0]            quat_z,
   output logic signed [QUAT_BITS-1:0]            quat_w
);

   import erq_pkg::*;

   localparam int      SH     = 61 - QUAT_BITS;
   localparam sum_type RND    = sum_type'(1) <<< (SH - 1);
   localparam sum_type LIM    = (sum_type'(1) <<< (QUAT_BITS - 1)) - sum_type'(1);
   localparam sum_type NLIM   = -LIM;
   localparam logic signed [63:0] RND30 = 64'sd1 <<< 29;
   // Components x and z take the difference of their two terms.
   localparam logic [3:0] SUB_MASK = 4'b0101;

   // Pair products: cp*sr, sp*cr, sp*sr, cp*cr.
   logic signed [63:0] wide [4];
   pair_type pair_in [4];
   pair_type pair_ff [4];
   xy_type   cy_ff;
   xy_type   sy_ff;

   term_type prod_in [8];
   term_type prod_ff [8];
   sum_type  sum_in  [4];
   sum_type  sum_ff  [4];
   sum_type  shifted [4];
   logic signed [QUAT_BITS-1:0] q_in [4];
   logic signed [QUAT_BITS-1:0] q_ff [4];

   assign wide[0] = cp * sr;
   assign wide[1] = sp * cr;
   assign wide[2] = sp * sr;
   assign wide[3] = cp * cr;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         pair_in[k] = pair_type'((wide[k] + RND30) >>> 30);
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         pair_ff <= pair_in;
         cy_ff   <= cy;
         sy_ff   <= sy;
      end
   end

   // Terms in component order: each component sums entries 2c and 2c+1.
   assign prod_in[0] = cy_ff * pair_ff[0];
   assign prod_in[1] = sy_ff * pair_ff[1];
   assign prod_in[2] = cy_ff * pair_ff[1];
   assign prod_in[3] = sy_ff * pair_ff[0];
   assign prod_in[4] = sy_ff * pair_ff[3];
   assign prod_in[5] = cy_ff * pair_ff[2];
   assign prod_in[6] = cy_ff * pair_ff[3];
   assign prod_in[7] = sy_ff * pair_ff[2];

   always_ff @(posedge clock) begin
      if (load[1]) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         if (SUB_MASK[c]) begin
            sum_in[c] = sum_type'(prod_ff[2*c]) - sum_type'(prod_ff[2*c+1]) + RND;
         end else begin
            sum_in[c] = sum_type'(prod_ff[2*c]) + sum_type'(prod_ff[2*c+1]) + RND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         sum_ff <= sum_in;
      end
   end

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         shifted[c] = sum_ff[c] >>> SH;
         priority if (shifted[c] > LIM) begin
            q_in[c] = LIM[QUAT_BITS-1:0];
         end else if (shifted[c] < NLIM) begin
            q_in[c] = NLIM[QUAT_BITS-1:0];
         end else begin
            q_in[c] = shifted[c][QUAT_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[3]) begin
         q_ff <= q_in;
      end
   end

   assign quat_x = q_ff[0];
   assign quat_y = q_ff[1];
   assign quat_z = q_ff[2];
   assign quat_w = q_ff[3];

endmodule
